// File: hw/rtl/confidence_tagged_alu_assert.svh
// Assertion macros for the confidence tagged ALU. They expect clk and arst_n in scope.
`ifndef CONFIDENCE_TAGGED_ALU_ASSERT_SVH
`define CONFIDENCE_TAGGED_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define CTA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cta assertion failed");
`define CTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cta assertion failed");
`else
`define CTA_ASSERT_IMPL(lbl, ante, cons)
`define CTA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/cta_pkg.sv
`timescale 1ns / 1ps

package cta_pkg;

	localparam int CTA_FRAC_BITS = 32;

	typedef enum logic [4:0] {
		OP_MUL  = 5'd0,
		OP_MUL3 = 5'd1,
		OP_DIV  = 5'd2,
		OP_DIV3 = 5'd3,
		OP_ADD  = 5'd4,
		OP_ADD3 = 5'd5,
		OP_SUB  = 5'd6,
		OP_SUB3 = 5'd7,
		OP_NEG  = 5'd8,
		OP_MIN  = 5'd9,
		OP_MIN3 = 5'd10,
		OP_MAX  = 5'd11,
		OP_MAX3 = 5'd12,
		OP_MULC = 5'd13,
		OP_DIVC = 5'd14,
		OP_ADDC = 5'd15,
		OP_SUBC = 5'd16
	} op_t;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// floor(s / 3) == (s * DIV3_RECIP) >> DIV3_SHIFT for every s below 2**18.
	localparam logic [17:0] DIV3_RECIP = 18'd174763;
	localparam int          DIV3_SHIFT = 19;

	// Side information that travels beside the two arithmetic units.
	typedef struct packed {
		logic        use_unit;
		logic [63:0] y2;
		logic        div2;
		logic [63:0] alt_val;
		logic        alt_sat;
		logic [15:0] conf;
		logic        sat1;
	} sb_t;

	// Applies a sign to a magnitude and saturates to 64 signed bits.
	// hi_nz flags magnitude bits above bit 63. Returns {saturated, value}.
	function automatic logic [64:0] fx_sat(input logic hi_nz, input logic [63:0] mag,
		input logic neg);
		logic        ovf;
		logic [63:0] v;
		if (neg) begin
			ovf = hi_nz | (mag[63] & (|mag[62:0]));
		end else begin
			ovf = hi_nz | mag[63];
		end
		if (ovf) begin
			v = neg ? S64_MIN : S64_MAX;
		end else begin
			v = neg ? (~mag + 64'd1) : mag;
		end
		return {ovf, v};
	endfunction

endpackage

// File: hw/rtl/cta_fxu.sv
`timescale 1ns / 1ps

// Fixed-point multiply or divide with saturation. Both datapaths run side by side
// and the last stage picks one.
module cta_fxu #(
	parameter int FRAC_BITS = cta_pkg::CTA_FRAC_BITS
) (
	input  logic        clk,
	input  logic        en,
	input  logic        is_div,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output logic [63:0] res_value,
	output logic        res_sat
);

	localparam int NW = 64 + FRAC_BITS;
	localparam int ND = NW - 3;
	localparam int RW = 128 - FRAC_BITS;
	localparam logic [127:0] RND_ADD = (128'd1 << FRAC_BITS) - 128'd1;

	logic [63:0] mx_s1, my_s1;
	logic        neg_s1, div_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= x[63] ? (~x + 64'd1) : x;
			my_s1  <= y[63] ? (~y + 64'd1) : y;
			neg_s1 <= x[63] ^ y[63];
			div_s1 <= is_div;
		end
	end

	// Multiply: four 32x32 partial products, a sum, a rounding shift, saturation.
	logic [63:0]   p00, p01, p10, p11;
	logic [63:0]   pp_s2 [4];
	logic          negm_s2, negm_s3, negm_s4;
	logic [127:0]  prod_s3;
	logic [127:0]  rsum;
	logic [RW-1:0] rnd_s4;
	logic [64:0]   mul_dly_s [ND];

	assign p00 = mx_s1[31:0] * my_s1[31:0];
	assign p01 = mx_s1[31:0] * my_s1[63:32];
	assign p10 = mx_s1[63:32] * my_s1[31:0];
	assign p11 = mx_s1[63:32] * my_s1[63:32];

	// A negative product floors, so its magnitude rounds up.
	assign rsum = prod_s3 + (negm_s3 ? RND_ADD : 128'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s2[0] <= p00;
			pp_s2[1] <= p01;
			pp_s2[2] <= p10;
			pp_s2[3] <= p11;
			negm_s2  <= neg_s1;
			prod_s3  <= {64'd0, pp_s2[0]} + {32'd0, pp_s2[1], 32'd0}
				+ {32'd0, pp_s2[2], 32'd0} + {pp_s2[3], 64'd0};
			negm_s3  <= negm_s2;
			rnd_s4   <= rsum[127:FRAC_BITS];
			negm_s4  <= negm_s3;
			mul_dly_s[0] <= cta_pkg::fx_sat(|rnd_s4[RW-1:64], rnd_s4[63:0], negm_s4);
			for (int k = 1; k < ND; k++) begin
				mul_dly_s[k] <= mul_dly_s[k-1];
			end
		end
	end

	// Divide: restoring division, one quotient bit per stage. The numerator
	// shifts out at the top while quotient bits shift in at the bottom.
	logic [63:0]   rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [63:0]   dm_s  [NW];
	logic          negd_s [NW];
	logic          sel_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [63:0]   rem_in, dm_in;
		logic [NW-1:0] num_in;
		logic          neg_in, sel_in;
		logic [64:0]   t;
		logic [64:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = {mx_s1, {FRAC_BITS{1'b0}}};
			assign dm_in  = my_s1;
			assign neg_in = neg_s1;
			assign sel_in = div_s1;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign dm_in  = dm_s[k-1];
			assign neg_in = negd_s[k-1];
			assign sel_in = sel_s[k-1];
		end

		assign t    = {rem_in, num_in[NW-1]};
		assign diff = t - {1'b0, dm_in};
		assign ge   = ~diff[64];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[63:0] : t[63:0];
				num_s[k]  <= {num_in[NW-2:0], ge};
				dm_s[k]   <= dm_in;
				negd_s[k] <= neg_in;
				sel_s[k]  <= sel_in;
			end
		end
	end

	logic [64:0] res_sn;

	always_ff @(posedge clk) begin
		if (en) begin
			if (sel_s[NW-1]) begin
				res_sn <= cta_pkg::fx_sat(|num_s[NW-1][NW-1:64], num_s[NW-1][63:0],
					negd_s[NW-1]);
			end else begin
				res_sn <= mul_dly_s[ND-1];
			end
		end
	end

	assign res_value = res_sn[63:0];
	assign res_sat   = res_sn[64];

endmodule

// File: hw/rtl/confidence_tagged_alu.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake                     Contents
// s_axis      in         s_axis_tvalid/s_axis_tready   operation, three operands with confidences
// m_axis      out        m_axis_tvalid/m_axis_tready   result value, confidence, saturation flag
// cfg         in         cfg_wr_en                     scalar register
//
// One item enters per cycle unless m_axis stalls; at the default FRAC_BITS values are Q32.32.
// The two dividers, which retire one quotient bit per stage, set the pipeline depth.
// Every item passes both units; two-operand work multiplies by 1.0 in the second.
// A stall on m_axis freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits and loads the scalar with 1.0.

`include "confidence_tagged_alu_assert.svh"

module confidence_tagged_alu #(
	parameter int FRAC_BITS = cta_pkg::CTA_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_value, a_conf, b_value, b_conf, c_value, c_conf
	input  logic [239:0] s_axis_tdata,
	// operation
	input  logic [4:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_value, result_conf
	output logic [79:0]  m_axis_tdata,
	// saturated
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_wr_en,
	input  logic [63:0]  cfg_wr_data
);

	localparam int NW  = 64 + FRAC_BITS;
	localparam int LAT = NW + 2;
	localparam logic [63:0] FX_ONE = 64'd1 << FRAC_BITS;

	logic [63:0] scalar_q;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scalar_q <= FX_ONE;
		end else if (cfg_wr_en) begin
			scalar_q <= cfg_wr_data;
		end
	end

	logic out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: input register.
	logic           vld_s1;
	cta_pkg::op_t   op_s1;
	logic [63:0]    a_s1, b_s1, c_s1;
	logic [15:0]    ac_s1, bc_s1, cc_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= cta_pkg::op_t'(s_axis_tuser);
			a_s1  <= s_axis_tdata[63:0];
			ac_s1 <= s_axis_tdata[79:64];
			b_s1  <= s_axis_tdata[143:80];
			bc_s1 <= s_axis_tdata[159:144];
			c_s1  <= s_axis_tdata[223:160];
			cc_s1 <= s_axis_tdata[239:224];
		end
	end

	// Operand routing, sums and min/max selection.
	logic [63:0] y1_c, y2_c, src1, src2, bq, cq, mm_val_c;
	logic [15:0] mm_conf_c;
	logic        div1_c, div2_c, neg1, use2, neg2, zero0;
	logic        lt_ba, lt_cb, lt_bc, lt_ab, lt_ca, lt_ac;
	logic [65:0] t0, t1x, t2x, t1, t2, sum_c;

	assign bq = (b_s1 == 64'd0) ? FX_ONE : b_s1;
	assign cq = (c_s1 == 64'd0) ? FX_ONE : c_s1;

	assign lt_ba = $signed(b_s1) < $signed(a_s1);
	assign lt_ab = $signed(a_s1) < $signed(b_s1);
	assign lt_cb = $signed(c_s1) < $signed(b_s1);
	assign lt_bc = $signed(b_s1) < $signed(c_s1);
	assign lt_ca = $signed(c_s1) < $signed(a_s1);
	assign lt_ac = $signed(a_s1) < $signed(c_s1);

	always_comb begin
		y1_c      = b_s1;
		div1_c    = 1'b0;
		y2_c      = FX_ONE;
		div2_c    = 1'b0;
		src1      = b_s1;
		neg1      = 1'b0;
		src2      = c_s1;
		use2      = 1'b0;
		neg2      = 1'b0;
		zero0     = 1'b0;
		mm_val_c  = a_s1;
		mm_conf_c = ac_s1;
		case (op_s1)
			cta_pkg::OP_MUL3: begin
				y2_c = c_s1;
			end
			cta_pkg::OP_DIV: begin
				y1_c   = bq;
				div1_c = 1'b1;
			end
			cta_pkg::OP_DIV3: begin
				y1_c   = bq;
				div1_c = 1'b1;
				y2_c   = cq;
				div2_c = 1'b1;
			end
			cta_pkg::OP_MULC: begin
				y1_c = scalar_q;
			end
			cta_pkg::OP_DIVC: begin
				y1_c   = scalar_q;
				div1_c = 1'b1;
			end
			cta_pkg::OP_ADD3: begin
				use2 = 1'b1;
			end
			cta_pkg::OP_SUB: begin
				neg1 = 1'b1;
			end
			cta_pkg::OP_SUB3: begin
				neg1 = 1'b1;
				use2 = 1'b1;
				neg2 = 1'b1;
			end
			cta_pkg::OP_NEG: begin
				zero0 = 1'b1;
				src1  = a_s1;
				neg1  = 1'b1;
			end
			cta_pkg::OP_ADDC: begin
				src1 = scalar_q;
			end
			cta_pkg::OP_SUBC: begin
				src1 = scalar_q;
				neg1 = 1'b1;
			end
			cta_pkg::OP_MIN: begin
				if (lt_ba) begin
					mm_val_c  = b_s1;
					mm_conf_c = bc_s1;
				end
			end
			cta_pkg::OP_MIN3: begin
				// Compare a with the smaller of b and c; ties keep a.
				if (lt_cb ? lt_ca : lt_ba) begin
					mm_val_c  = lt_cb ? c_s1 : b_s1;
					mm_conf_c = lt_cb ? cc_s1 : bc_s1;
				end
			end
			cta_pkg::OP_MAX: begin
				if (lt_ab) begin
					mm_val_c  = b_s1;
					mm_conf_c = bc_s1;
				end
			end
			cta_pkg::OP_MAX3: begin
				if (lt_bc ? lt_ac : lt_ab) begin
					mm_val_c  = lt_bc ? c_s1 : b_s1;
					mm_conf_c = lt_bc ? cc_s1 : bc_s1;
				end
			end
			default: begin
			end
		endcase
	end

	// Subtraction is the ones complement plus a carry in.
	assign t0    = zero0 ? 66'd0 : {{2{a_s1[63]}}, a_s1};
	assign t1x   = {{2{src1[63]}}, src1};
	assign t2x   = {{2{src2[63]}}, src2};
	assign t1    = neg1 ? ~t1x : t1x;
	assign t2    = use2 ? (neg2 ? ~t2x : t2x) : 66'd0;
	assign sum_c = t0 + t1 + t2 + {65'd0, neg1} + {65'd0, use2 & neg2};

	// Stage 2.
	logic           vld_s2;
	cta_pkg::op_t   op_s2;
	logic [65:0]    sum_s2;
	logic [63:0]    mm_val_s2, a_s2, x1_s2, y1_s2, y2_s2;
	logic [15:0]    mm_conf_s2, conf2_s2, ac_s2;
	logic [17:0]    csum3_s2;
	logic           dz_s2, div1_s2, div2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2      <= op_s1;
			sum_s2     <= sum_c;
			mm_val_s2  <= mm_val_c;
			mm_conf_s2 <= mm_conf_c;
			csum3_s2   <= {2'd0, ac_s1} + {2'd0, bc_s1} + {2'd0, cc_s1};
			conf2_s2   <= 16'(({1'b0, ac_s1} + {1'b0, bc_s1}) >> 1);
			ac_s2      <= ac_s1;
			a_s2       <= a_s1;
			dz_s2      <= (scalar_q == 64'd0);
			x1_s2      <= a_s1;
			y1_s2      <= y1_c;
			div1_s2    <= div1_c;
			y2_s2      <= y2_c;
			div2_s2    <= div2_c;
		end
	end

	// Saturated sums, the mean of three confidences and the side record.
	logic [35:0]    conf3_prod;
	logic [15:0]    conf3;
	logic           sum_ovf;
	logic [63:0]    sum_val;
	cta_pkg::sb_t   sb_c;

	assign conf3_prod = {18'd0, csum3_s2} * {18'd0, cta_pkg::DIV3_RECIP};
	assign conf3      = conf3_prod[cta_pkg::DIV3_SHIFT +: 16];
	assign sum_ovf    = !((sum_s2[65:63] == 3'b000) || (sum_s2[65:63] == 3'b111));
	assign sum_val    = sum_ovf ? (sum_s2[65] ? cta_pkg::S64_MIN : cta_pkg::S64_MAX)
		: sum_s2[63:0];

	always_comb begin
		sb_c          = '0;
		sb_c.y2       = y2_s2;
		sb_c.div2     = div2_s2;
		case (op_s2)
			cta_pkg::OP_MUL, cta_pkg::OP_DIV: begin
				sb_c.use_unit = 1'b1;
				sb_c.conf     = conf2_s2;
			end
			cta_pkg::OP_MUL3, cta_pkg::OP_DIV3: begin
				sb_c.use_unit = 1'b1;
				sb_c.conf     = conf3;
			end
			cta_pkg::OP_MULC: begin
				sb_c.use_unit = 1'b1;
				sb_c.conf     = ac_s2;
			end
			cta_pkg::OP_DIVC: begin
				sb_c.conf = ac_s2;
				if (dz_s2) begin
					// A zero scalar divisor saturates by the sign of a, or gives zero.
					sb_c.alt_sat = 1'b1;
					if (a_s2 != 64'd0) begin
						sb_c.alt_val = a_s2[63] ? cta_pkg::S64_MIN : cta_pkg::S64_MAX;
					end
				end else begin
					sb_c.use_unit = 1'b1;
				end
			end
			cta_pkg::OP_ADD, cta_pkg::OP_SUB: begin
				sb_c.alt_val = sum_val;
				sb_c.alt_sat = sum_ovf;
				sb_c.conf    = conf2_s2;
			end
			cta_pkg::OP_ADD3, cta_pkg::OP_SUB3: begin
				sb_c.alt_val = sum_val;
				sb_c.alt_sat = sum_ovf;
				sb_c.conf    = conf3;
			end
			cta_pkg::OP_NEG, cta_pkg::OP_ADDC, cta_pkg::OP_SUBC: begin
				sb_c.alt_val = sum_val;
				sb_c.alt_sat = sum_ovf;
				sb_c.conf    = ac_s2;
			end
			cta_pkg::OP_MIN, cta_pkg::OP_MIN3, cta_pkg::OP_MAX, cta_pkg::OP_MAX3: begin
				sb_c.alt_val = mm_val_s2;
				sb_c.conf    = mm_conf_s2;
			end
			default: begin
				sb_c.y2   = FX_ONE;
				sb_c.div2 = 1'b0;
			end
		endcase
	end

	// Stage 3.
	logic           vld_s3;
	logic [63:0]    x1_s3, y1_s3;
	logic           div1_s3;
	cta_pkg::sb_t   sb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s3   <= x1_s2;
			y1_s3   <= y1_s2;
			div1_s3 <= div1_s2;
			sb_s3   <= sb_c;
		end
	end

	logic [63:0] u1_val, u2_val;
	logic        u1_sat, u2_sat;

	cta_fxu #(
		.FRAC_BITS(FRAC_BITS)
	) u_fxu1 (
		.clk       (clk),
		.en        (en),
		.is_div    (div1_s3),
		.x         (x1_s3),
		.y         (y1_s3),
		.res_value (u1_val),
		.res_sat   (u1_sat)
	);

	cta_pkg::sb_t sb_a_s [LAT];
	cta_pkg::sb_t sb_b_s [LAT];
	cta_pkg::sb_t sb_mid;
	logic [LAT-1:0] vld_a, vld_b;

	always_comb begin
		sb_mid      = sb_a_s[LAT-1];
		sb_mid.sat1 = u1_sat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_a_s[0] <= sb_s3;
			sb_b_s[0] <= sb_mid;
			for (int k = 1; k < LAT; k++) begin
				sb_a_s[k] <= sb_a_s[k-1];
				sb_b_s[k] <= sb_b_s[k-1];
			end
		end
	end

	// The second step of three-operand mul and div; 1.0 for everything else.
	cta_fxu #(
		.FRAC_BITS(FRAC_BITS)
	) u_fxu2 (
		.clk       (clk),
		.en        (en),
		.is_div    (sb_a_s[LAT-1].div2),
		.x         (u1_val),
		.y         (sb_a_s[LAT-1].y2),
		.res_value (u2_val),
		.res_sat   (u2_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_a     <= '0;
			vld_b     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_a     <= {vld_a[LAT-2:0], vld_s3};
			vld_b     <= {vld_b[LAT-2:0], vld_a[LAT-1]};
			out_vld_q <= vld_b[LAT-1];
		end
	end

	logic [63:0] out_val_q;
	logic [15:0] out_conf_q;
	logic        out_sat_q;

	always_ff @(posedge clk) begin
		if (en) begin
			out_conf_q <= sb_b_s[LAT-1].conf;
			if (sb_b_s[LAT-1].use_unit) begin
				out_val_q <= u2_val;
				out_sat_q <= sb_b_s[LAT-1].sat1 | u2_sat;
			end else begin
				out_val_q <= sb_b_s[LAT-1].alt_val;
				out_sat_q <= sb_b_s[LAT-1].alt_sat;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_conf_q, out_val_q};
	assign m_axis_tuser  = out_sat_q;

	`CTA_ASSERT_IMPL(a_out_known, out_vld_q, !$isunknown({out_val_q, out_conf_q, out_sat_q}))
	`CTA_ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_a) && $stable(vld_b) && $stable(out_vld_q))
	`CTA_ASSERT_IMPL(a_out_from_pipe, $rose(out_vld_q), $past(vld_b[LAT-1]) && $past(en))

endmodule

// File: tb/tb_confidence_tagged_alu.sv
`timescale 1ns / 1ps

module tb_confidence_tagged_alu;

	localparam int FB = cta_pkg::CTA_FRAC_BITS;
	localparam int LATENCY = 2 * FB + 136;
	localparam logic [63:0] FX_ONE = 64'd1 << FB;

	typedef struct packed {
		logic [4:0]  op;
		logic [63:0] av;
		logic [15:0] ac;
		logic [63:0] bv;
		logic [15:0] bc;
		logic [63:0] cv;
		logic [15:0] cc;
	} alu_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] conf;
		logic        sat;
	} alu_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [239:0] s_axis_tdata = '0;
	logic [4:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [79:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         cfg_wr_en = 1'b0;
	logic [63:0]  cfg_wr_data = '0;

	confidence_tagged_alu dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	alu_item_t   pending_items[$];
	alu_result_t expected_results[$];
	logic [63:0] scalar_model = FX_ONE;
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_sender = 1'b0;
	logic        in_accepted = 1'b0;

	// Clamp a 130-bit signed value into 64 signed bits.
	function automatic logic [63:0] clamp64(input logic signed [129:0] x, inout logic sat);
		if (x > 130'sh7FFF_FFFF_FFFF_FFFF) begin
			sat = 1'b1;
			return cta_pkg::S64_MAX;
		end
		if (x < -130'sh8000_0000_0000_0000) begin
			sat = 1'b1;
			return cta_pkg::S64_MIN;
		end
		return x[63:0];
	endfunction

	function automatic logic [63:0] fx_mul_model(input logic [63:0] a, input logic [63:0] b,
		inout logic sat);
		logic signed [129:0] p;
		p = $signed({{66{a[63]}}, a}) * $signed({{66{b[63]}}, b});
		p = p >>> FB;
		return clamp64(p, sat);
	endfunction

	// Quotient truncated toward zero; d is nonzero.
	function automatic logic [63:0] fx_div_model(input logic [63:0] a, input logic [63:0] d,
		inout logic sat);
		logic signed [129:0] n;
		logic signed [129:0] q;
		n = $signed({{66{a[63]}}, a}) <<< FB;
		q = n / $signed({{66{d[63]}}, d});
		return clamp64(q, sat);
	endfunction

	function automatic logic [63:0] sum_model(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] c, input logic neg_b, input logic neg_c, inout logic sat);
		logic signed [129:0] s;
		logic signed [129:0] wb;
		logic signed [129:0] wc;
		wb = $signed({{66{b[63]}}, b});
		wc = $signed({{66{c[63]}}, c});
		s = $signed({{66{a[63]}}, a}) + (neg_b ? -wb : wb) + (neg_c ? -wc : wc);
		return clamp64(s, sat);
	endfunction

	function automatic alu_result_t predict_alu(input alu_item_t it, input logic [63:0] scl);
		alu_result_t r;
		logic [17:0] c2, c3;
		logic [63:0] qb, qc, v;
		logic [15:0] cf;
		logic        sat;
		c2 = ({2'b0, it.ac} + {2'b0, it.bc}) >> 1;
		c3 = ({2'b0, it.ac} + {2'b0, it.bc} + {2'b0, it.cc}) / 18'd3;
		qb = (it.bv == 64'd0) ? FX_ONE : it.bv;
		qc = (it.cv == 64'd0) ? FX_ONE : it.cv;
		sat = 1'b0;
		v = '0;
		cf = it.ac;
		case (it.op)
			cta_pkg::OP_MUL: begin v = fx_mul_model(it.av, it.bv, sat); cf = c2[15:0]; end
			cta_pkg::OP_MUL3: begin
				v = fx_mul_model(fx_mul_model(it.av, it.bv, sat), it.cv, sat);
				cf = c3[15:0];
			end
			cta_pkg::OP_DIV: begin v = fx_div_model(it.av, qb, sat); cf = c2[15:0]; end
			cta_pkg::OP_DIV3: begin
				v = fx_div_model(fx_div_model(it.av, qb, sat), qc, sat);
				cf = c3[15:0];
			end
			cta_pkg::OP_ADD: begin
				v = sum_model(it.av, it.bv, 64'd0, 1'b0, 1'b0, sat);
				cf = c2[15:0];
			end
			cta_pkg::OP_ADD3: begin
				v = sum_model(it.av, it.bv, it.cv, 1'b0, 1'b0, sat);
				cf = c3[15:0];
			end
			cta_pkg::OP_SUB: begin
				v = sum_model(it.av, it.bv, 64'd0, 1'b1, 1'b0, sat);
				cf = c2[15:0];
			end
			cta_pkg::OP_SUB3: begin
				v = sum_model(it.av, it.bv, it.cv, 1'b1, 1'b1, sat);
				cf = c3[15:0];
			end
			cta_pkg::OP_NEG: v = sum_model(64'd0, it.av, 64'd0, 1'b1, 1'b0, sat);
			cta_pkg::OP_MIN: begin
				v = it.av;
				if ($signed(it.bv) < $signed(v)) begin v = it.bv; cf = it.bc; end
			end
			cta_pkg::OP_MIN3: begin
				v = it.bv; cf = it.bc;
				if ($signed(it.cv) < $signed(v)) begin v = it.cv; cf = it.cc; end
				if ($signed(v) >= $signed(it.av)) begin v = it.av; cf = it.ac; end
			end
			cta_pkg::OP_MAX: begin
				v = it.av;
				if ($signed(v) < $signed(it.bv)) begin v = it.bv; cf = it.bc; end
			end
			cta_pkg::OP_MAX3: begin
				v = it.bv; cf = it.bc;
				if ($signed(v) < $signed(it.cv)) begin v = it.cv; cf = it.cc; end
				if ($signed(it.av) >= $signed(v)) begin v = it.av; cf = it.ac; end
			end
			cta_pkg::OP_MULC: v = fx_mul_model(it.av, scl, sat);
			cta_pkg::OP_DIVC: begin
				if (scl == 64'd0) begin
					sat = 1'b1;
					v = (it.av == 64'd0) ? 64'd0
						: (it.av[63] ? cta_pkg::S64_MIN : cta_pkg::S64_MAX);
				end else begin
					v = fx_div_model(it.av, scl, sat);
				end
			end
			cta_pkg::OP_ADDC: v = sum_model(it.av, scl, 64'd0, 1'b0, 1'b0, sat);
			cta_pkg::OP_SUBC: v = sum_model(it.av, scl, 64'd0, 1'b1, 1'b0, sat);
			default: begin v = '0; cf = '0; sat = 1'b0; end
		endcase
		r.value = v;
		r.conf = cf;
		r.sat = sat;
		return r;
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = 64'd0;
			1: v = cta_pkg::S64_MAX;
			2: v = cta_pkg::S64_MIN;
			3: v = FX_ONE;
			4: v = -FX_ONE;
			5, 6: v = {{32{v[40]}}, v[31:0]} >>> $urandom_range(0, 24);
			7: v = {{28{v[35]}}, v[35:0]};
			default: ;
		endcase
		return v;
	endfunction

	function automatic alu_item_t rand_item();
		alu_item_t it;
		it.op = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(17, 31))
			: 5'($urandom_range(0, 16));
		it.av = rand_value();
		it.bv = rand_value();
		it.cv = rand_value();
		it.ac = 16'($urandom);
		it.bc = 16'($urandom);
		it.cc = 16'($urandom);
		return it;
	endfunction

	// Driver: valid stays high across back-to-back items.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_accepted) begin
				if (pending_items.size() > 0 && !hold_sender
					&& $urandom_range(0, 99) >= send_idle_pct) begin
					alu_item_t it;
					it = pending_items.pop_front();
					s_axis_tdata <= {it.cc, it.cv, it.bc, it.bv, it.ac, it.av};
					s_axis_tuser <= it.op;
					s_axis_tvalid <= 1'b1;
					expected_results.push_back(predict_alu(it, scalar_model));
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor; it also records whether the driven item was taken at this edge.
	always @(posedge clk) begin
		in_accepted = s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation: %h", m_axis_tdata);
				errors++;
			end else begin
				alu_result_t e;
				e = expected_results.pop_front();
				if (m_axis_tdata[63:0] !== e.value) begin
					$error("result_value expected %h actual %h", e.value, m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[79:64] !== e.conf) begin
					$error("result_conf expected %h actual %h", e.conf, m_axis_tdata[79:64]);
					errors++;
				end
				if (m_axis_tuser[0] !== e.sat) begin
					$error("saturated expected %b actual %b", e.sat, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_scalar(input logic [63:0] v);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		scalar_model = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_op(input logic [4:0] op, input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] c);
		alu_item_t it;
		it.op = op;
		it.av = a;
		it.bv = b;
		it.cv = c;
		it.ac = 16'hFFFF;
		it.bc = 16'hFFFF;
		it.cc = 16'hFFFE;
		pending_items.push_back(it);
	endtask

	initial begin
		logic [63:0] scalars[6];
		scalars = '{64'd0, cta_pkg::S64_MAX, cta_pkg::S64_MIN, -FX_ONE,
			64'h0000_0003_8000_0000, 64'd1};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: each operation, extremes, ties, zero divisors, most-negative negation.
		for (int op = 0; op <= 16; op++)
			push_op(5'(op), 64'h0000_0002_4000_0000, 64'hFFFF_FFFD_0000_0000, 64'd0);
		push_op(cta_pkg::OP_NEG, cta_pkg::S64_MIN, 64'd0, 64'd0);
		push_op(cta_pkg::OP_MUL3, cta_pkg::S64_MAX, cta_pkg::S64_MAX, cta_pkg::S64_MIN);
		push_op(cta_pkg::OP_DIV3, cta_pkg::S64_MIN, 64'd0, 64'd1);
		push_op(cta_pkg::OP_MIN3, 64'd5, 64'd5, 64'd5);
		push_op(cta_pkg::OP_MAX3, 64'd7, 64'd9, 64'd9);
		push_op(cta_pkg::OP_SUB3, cta_pkg::S64_MIN, cta_pkg::S64_MAX, cta_pkg::S64_MAX);
		push_op(cta_pkg::OP_ADD3, cta_pkg::S64_MAX, cta_pkg::S64_MAX, 64'd1);
		push_op(5'd31, cta_pkg::S64_MAX, cta_pkg::S64_MAX, cta_pkg::S64_MAX);
		begin
			alu_item_t z;
			z = '0;
			z.op = cta_pkg::OP_MIN;
			pending_items.push_back(z);
		end

		for (int phase = 0; phase < 6; phase++) begin
			write_scalar(phase == 0 ? FX_ONE : scalars[phase - 1]);
			send_idle_pct = (phase < 2) ? 35 : (phase < 4) ? 45 : 0;
			recv_idle_pct = (phase < 2) ? 45 : (phase < 4) ? 35 : 0;
			for (int i = 0; i < 275; i++) begin
				alu_item_t it;
				it = rand_item();
				if (phase >= 1 && $urandom_range(0, 3) == 0) it.av = 64'd0;
				pending_items.push_back(it);
			end
			if (phase == 3) begin
				// Hold the sender until the pipeline is empty, then resume.
				while (pending_items.size() > 137) @(posedge clk);
				hold_sender = 1'b1;
				while (s_axis_tvalid || expected_results.size() > 0) @(posedge clk);
				hold_sender = 1'b0;
			end
		end
		write_scalar(scalars[5]);
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_confidence_tagged_alu OK");
		end else begin
			$display("tb_confidence_tagged_alu NOT OK");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_confidence_tagged_alu NOT OK");
		$finish;
	end

endmodule
